/* hdl/pdc_pkg.sv */
// Shared types and constants for the PID position/delta controller.
`default_nettype none

package pdc_pkg;

    localparam int GAIN_W      = 16;
    localparam int DRIVE_W     = 32;
    localparam int LIMIT_W     = 31;
    localparam int THR_W       = 17;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 3;

    localparam logic MODE_POSITION = 1'b0;
    localparam logic MODE_DELTA    = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_KP_GAIN     = 3'd1,
        REG_KI_GAIN     = 3'd2,
        REG_KD_GAIN     = 3'd3,
        REG_OUT_LIMIT   = 3'd4,
        REG_INT_LIMIT   = 3'd5,
        REG_SEP_THRESH  = 3'd6,
        REG_SEP_ENABLE  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic                     mode;
        logic signed [GAIN_W-1:0] kp_gain;
        logic signed [GAIN_W-1:0] ki_gain;
        logic signed [GAIN_W-1:0] kd_gain;
        logic [LIMIT_W-1:0]       output_limit;
        logic [LIMIT_W-1:0]       integral_limit;
        logic [THR_W-1:0]         separation_threshold;
        logic                     separation_enable;
    } cfg_t;

endpackage

`default_nettype wire

/* hdl/pdc_cfg.sv */
// Configuration register file of the PID controller.
`default_nettype none

module pdc_cfg
    import pdc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MODE:       cfg_next.mode                 = cfg_data[0];
                REG_KP_GAIN:    cfg_next.kp_gain              = cfg_data[GAIN_W-1:0];
                REG_KI_GAIN:    cfg_next.ki_gain              = cfg_data[GAIN_W-1:0];
                REG_KD_GAIN:    cfg_next.kd_gain              = cfg_data[GAIN_W-1:0];
                REG_OUT_LIMIT:  cfg_next.output_limit         = cfg_data[LIMIT_W-1:0];
                REG_INT_LIMIT:  cfg_next.integral_limit       = cfg_data[LIMIT_W-1:0];
                REG_SEP_THRESH: cfg_next.separation_threshold = cfg_data[THR_W-1:0];
                REG_SEP_ENABLE: cfg_next.separation_enable    = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/pdc_step.sv */
// One controller step: error history, P/I/D terms, integral and output clamps.
`default_nettype none

module pdc_step
    import pdc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire cfg_t                        cfg,
    input  wire logic signed [SAMPLE_WIDTH-1:0] measured,
    input  wire logic signed [SAMPLE_WIDTH-1:0] target,
    input  wire logic signed [SAMPLE_WIDTH:0]   err_now,
    input  wire logic signed [SAMPLE_WIDTH:0]   err_prev,
    input  wire logic signed [DRIVE_W-1:0]      integral,
    input  wire logic signed [DRIVE_W-1:0]      drive,
    output logic signed [SAMPLE_WIDTH:0]        err_new,
    output logic signed [DRIVE_W-1:0]           integral_new,
    output logic signed [DRIVE_W-1:0]           drive_new
);

    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int D1_W   = SAMPLE_WIDTH + 2;
    localparam int D2_W   = SAMPLE_WIDTH + 3;
    localparam int PROD_W = GAIN_W + D2_W;
    localparam int ACC_W  = ((PROD_W > DRIVE_W) ? PROD_W : DRIVE_W) + 3;
    localparam int CMP_W  = (ERR_W > THR_W) ? ERR_W : THR_W;

    function automatic logic signed [ACC_W-1:0] clamp_sym(
        input logic signed [ACC_W-1:0] x,
        input logic [LIMIT_W-1:0]      lim
    );
        logic signed [ACC_W-1:0] pos;
        logic signed [ACC_W-1:0] neg;
        pos = $signed(ACC_W'(lim));
        neg = -pos;
        if (x > pos)
            return pos;
        else if (x < neg)
            return neg;
        else
            return x;
    endfunction

    logic signed [ERR_W-1:0]         e;
    logic signed [D1_W-1:0]          d1;
    logic signed [D2_W-1:0]          d2;
    logic signed [D1_W-1:0]          p_opd;
    logic signed [D2_W-1:0]          d_opd;
    logic signed [GAIN_W+D1_W-1:0]   p_term;
    logic signed [PROD_W-1:0]        d_term;
    logic signed [GAIN_W+ERR_W-1:0]  i_prod;
    logic [ERR_W-1:0]                mag;
    logic                            use_i;
    logic signed [ACC_W-1:0]         i_sum;
    logic signed [ACC_W-1:0]         i_clamped;
    logic signed [ACC_W-1:0]         base;
    logic signed [ACC_W-1:0]         sum;
    logic signed [ACC_W-1:0]         drive_clamped;

    always_comb
    begin
        e  = $signed(ERR_W'(target)) - $signed(ERR_W'(measured));
        d1 = $signed(D1_W'(e)) - $signed(D1_W'(err_now));
        d2 = $signed(D2_W'(e)) - ($signed(D2_W'(err_now)) <<< 1) + $signed(D2_W'(err_prev));

        p_opd = (cfg.mode == MODE_DELTA) ? d1 : $signed(D1_W'(e));
        d_opd = (cfg.mode == MODE_DELTA) ? d2 : $signed(D2_W'(d1));

        p_term = $signed(cfg.kp_gain) * p_opd;
        d_term = $signed(cfg.kd_gain) * d_opd;
        i_prod = $signed(cfg.ki_gain) * e;

        mag   = e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
        use_i = !cfg.separation_enable
                || (CMP_W'(mag) < CMP_W'(cfg.separation_threshold));

        if (cfg.mode == MODE_DELTA)
        begin
            i_sum = $signed(ACC_W'(i_prod));
            base  = $signed(ACC_W'(drive));
        end
        else
        begin
            i_sum = $signed(ACC_W'(integral)) + $signed(ACC_W'(i_prod));
            base  = '0;
        end
        i_clamped = clamp_sym(i_sum, cfg.integral_limit);

        sum = base + $signed(ACC_W'(p_term)) + $signed(ACC_W'(d_term))
              + (use_i ? i_clamped : '0);
        drive_clamped = clamp_sym(sum, cfg.output_limit);

        err_new      = e;
        integral_new = i_clamped[DRIVE_W-1:0];
        drive_new    = drive_clamped[DRIVE_W-1:0];
    end

endmodule

`default_nettype wire

/* hdl/pid_position_delta_controller.sv */
// Top level of the PID controller: input register, state, result register.
// Each transfer on the sample channel yields one drive result. A sample is
// held in an input register; from there the error, the three gain products,
// the integral and output clamps are formed in one pass and written to the
// result register together with the controller state once the result
// register is free. A new sample is taken every cycle, limited only by
// drive_ready. Configuration writes are registered and must be made while
// no sample is in flight.
`default_nettype none

module pid_position_delta_controller
    import pdc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          cfg_data,
    input  wire logic                           sample_valid,
    output logic                                sample_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] measured,
    input  wire logic signed [SAMPLE_WIDTH-1:0] target,
    output logic                                drive_valid,
    input  wire logic                           drive_ready,
    output logic signed [DRIVE_W-1:0]           drive
);

    cfg_t cfg;

    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] measured_reg;
    logic signed [SAMPLE_WIDTH-1:0] target_reg;
    logic signed [SAMPLE_WIDTH:0]   err_now_reg;
    logic signed [SAMPLE_WIDTH:0]   err_prev_reg;
    logic signed [DRIVE_W-1:0]      integral_reg;
    logic signed [DRIVE_W-1:0]      drive_reg;
    logic                           out_valid_reg;

    logic signed [SAMPLE_WIDTH:0]   err_next;
    logic signed [DRIVE_W-1:0]      integral_next;
    logic signed [DRIVE_W-1:0]      drive_next;
    logic                           advance;
    logic                           take;

    pdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdc_step #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_step (
        .cfg          (cfg),
        .measured     (measured_reg),
        .target       (target_reg),
        .err_now      (err_now_reg),
        .err_prev     (err_prev_reg),
        .integral     (integral_reg),
        .drive        (drive_reg),
        .err_new      (err_next),
        .integral_new (integral_next),
        .drive_new    (drive_next)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || drive_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign take         = sample_valid && sample_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            err_now_reg   <= '0;
            err_prev_reg  <= '0;
            integral_reg  <= '0;
            drive_reg     <= '0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                err_prev_reg  <= err_now_reg;
                err_now_reg   <= err_next;
                integral_reg  <= integral_next;
                drive_reg     <= drive_next;
            end
            else if (drive_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            measured_reg <= measured;
            target_reg   <= target;
        end
    end

    assign drive_valid = out_valid_reg;
    assign drive       = drive_reg;

endmodule

`default_nettype wire

/* tb/tb_pid_position_delta_controller.sv */
// Self-checking testbench for the positional/incremental PID drive controller.
`timescale 1ns / 100ps

module tb_pid_position_delta_controller;
    import pdc_pkg::*;

    localparam int SW          = 16;
    localparam int STUCK_LIMIT = 5000;
    localparam logic [LIMIT_W-1:0] LIM_MAX = {LIMIT_W{1'b1}};

    typedef struct {
        logic signed [SW-1:0] meas;
        logic signed [SW-1:0] targ;
        bit                   drain;
    } sample_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0]        cfg_index    = '0;
    logic [CFG_DATA_W-1:0]         cfg_data     = '0;
    logic                          sample_valid = 1'b0;
    logic                          sample_ready;
    logic signed [SW-1:0]          measured     = '0;
    logic signed [SW-1:0]          target       = '0;
    logic                          drive_valid;
    logic                          drive_ready  = 1'b0;
    logic signed [DRIVE_W-1:0]     drive;

    sample_t                       sample_queue[$];
    logic signed [DRIVE_W-1:0]     expected_drive[$];
    sample_t                       next_item;
    logic signed [DRIVE_W-1:0]     drive_want;

    cfg_t                          shadow = '0;
    longint                        err_now   = 0;
    longint                        err_prev  = 0;
    longint                        err_prev2 = 0;
    longint                        integ_acc = 0;
    longint                        drive_acc = 0;

    bit                            idle_on      = 1'b1;
    int                            send_gap     = 0;
    int                            stall_left   = 0;
    int                            stuck_cycles = 0;
    int                            fail_count   = 0;

    pid_position_delta_controller #(.SAMPLE_WIDTH(SW)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .measured     (measured),
        .target       (target),
        .drive_valid  (drive_valid),
        .drive_ready  (drive_ready),
        .drive        (drive)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_sym(longint x, longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // Advances the controller state by one sample and returns the drive value.
    function automatic logic signed [DRIVE_W-1:0] next_drive(logic signed [SW-1:0] meas,
                                                              logic signed [SW-1:0] targ);
        longint kp, ki, kd, olim, ilim, mag, p, d, sum;
        bit     use_i;
        kp   = $signed(shadow.kp_gain);
        ki   = $signed(shadow.ki_gain);
        kd   = $signed(shadow.kd_gain);
        olim = shadow.output_limit;
        ilim = shadow.integral_limit;
        err_prev2 = err_prev;
        err_prev  = err_now;
        err_now   = longint'(targ) - longint'(meas);
        mag   = (err_now < 0) ? -err_now : err_now;
        use_i = !shadow.separation_enable || (mag < longint'(shadow.separation_threshold));
        if (shadow.mode == MODE_POSITION)
        begin
            p         = kp * err_now;
            integ_acc = clamp_sym(integ_acc + ki * err_now, ilim);
            d         = kd * (err_now - err_prev);
            sum       = p + d + (use_i ? integ_acc : 0);
        end
        else
        begin
            p         = kp * (err_now - err_prev);
            integ_acc = clamp_sym(ki * err_now, ilim);
            d         = kd * (err_now - 2 * err_prev + err_prev2);
            sum       = drive_acc + p + d + (use_i ? integ_acc : 0);
        end
        drive_acc = clamp_sym(sum, olim);
        return drive_acc[DRIVE_W-1:0];
    endfunction

    // Sample driver; predicts each transfer as it happens.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            send_gap     <= 0;
        end
        else
        begin
            if (sample_valid && sample_ready)
                expected_drive.push_back(next_drive(measured, target));
            if (!sample_valid || sample_ready)
            begin
                if (send_gap > 0)
                begin
                    sample_valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end
                else if (sample_queue.size() > 0 &&
                         !(sample_queue[0].drain && expected_drive.size() > 0))
                begin
                    next_item     = sample_queue.pop_front();
                    sample_valid <= 1'b1;
                    measured     <= next_item.meas;
                    target       <= next_item.targ;
                    if (idle_on && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(1, 12);
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Drive monitor with random backpressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_ready <= 1'b0;
            stall_left  <= 0;
        end
        else
        begin
            if (drive_valid && drive_ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    $display("%0t: unexpected drive transfer, expected none, actual %0d",
                             $time, drive);
                    fail_count++;
                end
                else
                begin
                    drive_want = expected_drive.pop_front();
                    if (drive !== drive_want)
                    begin
                        $display("%0t: drive mismatch, expected %0d, actual %0d",
                                 $time, drive_want, drive);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                drive_ready <= 1'b0;
                stall_left  <= stall_left - 1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                drive_ready <= 1'b0;
                stall_left  <= $urandom_range(0, 11);
            end
            else
            begin
                drive_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (sample_valid && sample_ready) || (drive_valid && drive_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb_pid_position_delta_controller failed");
            $finish;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_MODE:       shadow.mode                 = val[0];
            REG_KP_GAIN:    shadow.kp_gain              = val[GAIN_W-1:0];
            REG_KI_GAIN:    shadow.ki_gain              = val[GAIN_W-1:0];
            REG_KD_GAIN:    shadow.kd_gain              = val[GAIN_W-1:0];
            REG_OUT_LIMIT:  shadow.output_limit         = val[LIMIT_W-1:0];
            REG_INT_LIMIT:  shadow.integral_limit       = val[LIMIT_W-1:0];
            REG_SEP_THRESH: shadow.separation_threshold = val[THR_W-1:0];
            REG_SEP_ENABLE: shadow.separation_enable    = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_controller(input logic m, input logic signed [GAIN_W-1:0] kp,
                                  input logic signed [GAIN_W-1:0] ki,
                                  input logic signed [GAIN_W-1:0] kd,
                                  input logic [LIMIT_W-1:0] olim, input logic [LIMIT_W-1:0] ilim,
                                  input logic [THR_W-1:0] thr, input logic en);
        // upper data bits of the one-bit registers carry noise
        write_reg(REG_MODE, {(CFG_DATA_W-1)'($urandom), m});
        write_reg(REG_KP_GAIN, CFG_DATA_W'(kp));
        write_reg(REG_KI_GAIN, CFG_DATA_W'(ki));
        write_reg(REG_KD_GAIN, CFG_DATA_W'(kd));
        write_reg(REG_OUT_LIMIT, olim);
        write_reg(REG_INT_LIMIT, ilim);
        write_reg(REG_SEP_THRESH, CFG_DATA_W'(thr));
        write_reg(REG_SEP_ENABLE, {(CFG_DATA_W-1)'($urandom), en});
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || sample_valid || expected_drive.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_sample(input logic signed [SW-1:0] m, input logic signed [SW-1:0] t);
        sample_t s;
        s.meas  = m;
        s.targ  = t;
        s.drain = 1'b0;
        sample_queue.push_back(s);
    endtask

    function automatic logic signed [GAIN_W-1:0] rand_gain();
        if ($urandom_range(0, 1) == 0)
            return GAIN_W'($urandom);
        return GAIN_W'($urandom_range(0, 1024) - 512);
    endfunction

    function automatic logic [LIMIT_W-1:0] rand_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LIM_MAX;
            2, 3:    return LIMIT_W'($urandom_range(0, 1 << 22));
            default: return LIMIT_W'($urandom);
        endcase
    endfunction

    function automatic logic [THR_W-1:0] rand_thr();
        if ($urandom_range(0, 2) == 0)
            return THR_W'($urandom);
        return THR_W'($urandom_range(0, 2000));
    endfunction

    // Mostly a plant tracking its setpoint, with full-range noise mixed in.
    task automatic random_samples(input int n);
        sample_t s;
        for (int i = 0; i < n; i++)
        begin
            s.targ = SW'($urandom);
            if ($urandom_range(0, 3) == 0)
                s.meas = SW'($urandom);
            else
                s.meas = s.targ + SW'($urandom_range(0, 128)) - SW'(64);
            s.drain = (i == n / 2);
            sample_queue.push_back(s);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // positional, plain gains, open limits
        set_controller(MODE_POSITION, 16'sd256, 16'sd128, 16'sd64, LIM_MAX, LIM_MAX, '0, 1'b0);
        push_sample(16'sd0, 16'sd0);
        push_sample(16'sd32767, -16'sd32768);
        push_sample(16'sd32767, -16'sd32768);
        push_sample(-16'sd32768, 16'sd32767);
        push_sample(-16'sd1, 16'sd0);
        push_sample(16'sd5, 16'sd5);
        wait_idle();

        // extreme gains against tight output and integral clamps
        set_controller(MODE_POSITION, 16'sd32767, -16'sd32768, -16'sd32768,
                       31'd5000, 31'd1000, '0, 1'b0);
        push_sample(-16'sd32768, 16'sd32767);
        push_sample(16'sd32767, -16'sd32768);
        push_sample(16'sd0, 16'sd1);
        wait_idle();

        // zero limits pin everything to zero
        set_controller(MODE_DELTA, -16'sd32768, 16'sd32767, 16'sd32767, '0, '0, '0, 1'b0);
        push_sample(16'sd0, 16'sd32767);
        push_sample(16'sd32767, 16'sd0);
        push_sample(-16'sd32768, -16'sd32768);
        wait_idle();

        // integral separation around the threshold, delta form
        set_controller(MODE_DELTA, 16'sd16, 16'sd256, 16'sd8, LIM_MAX, LIM_MAX, 17'd1000, 1'b1);
        push_sample(16'sd0, 16'sd999);
        push_sample(16'sd0, 16'sd1000);
        push_sample(16'sd0, -16'sd1000);
        push_sample(16'sd0, -16'sd999);
        push_sample(16'sd32767, -16'sd32768);
        push_sample(16'sd500, -16'sd500);
        wait_idle();

        // largest threshold never separates
        set_controller(MODE_POSITION, 16'sd100, 16'sd300, -16'sd50, LIM_MAX, 31'd1000000,
                       {THR_W{1'b1}}, 1'b1);
        push_sample(-16'sd32768, 16'sd32767);
        push_sample(16'sd0, 16'sd7);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            set_controller(1'($urandom), rand_gain(), rand_gain(), rand_gain(),
                           rand_limit(), rand_limit(), rand_thr(), 1'($urandom));
            if (ph == 7)
                idle_on = 1'b0;
            random_samples(50);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_drive.size() == 0)
            $display("tb_pid_position_delta_controller passed");
        else
            $display("tb_pid_position_delta_controller failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/pdc_pkg.sv
hdl/pdc_cfg.sv
hdl/pdc_step.sv
hdl/pid_position_delta_controller.sv
tb/tb_pid_position_delta_controller.sv
